// ===== rtl/ppu_pkg.sv =====
package ppu_pkg;

    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_DATA_W   = 320;
    localparam int OUT_DATA_W  = 168;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [16:0] AGE_ONE = 17'h10000;
    localparam logic [16:0] AGE_MAX = 17'h1FFFF;

    // one pool entry, as held in the particle ram
    typedef struct packed {
        logic [47:0] motion;  // damping 15..0, spin 31..16, angle 47..32
        logic [31:0] size;    // begin low, end high
        logic [63:0] colour;  // begin low, end high
        logic [31:0] rate;
        logic [16:0] age;
        logic [47:0] axis;
        logic [47:0] vel;
        logic [47:0] pos;
    } t_entry;

    typedef struct packed {
        logic        cmd;
        logic [15:0] dt;
        t_entry      entry;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RD,
        B_M1,
        B_M2,
        B_M3,
        B_MVRD,
        B_MVWR,
        B_ERD,
        B_EL,
        B_HOLD
    } t_bstate;

    function automatic logic [15:0] sat16(input logic signed [25:0] v);
        logic [15:0] r;
        if (v > 26'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -26'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [16:0] t);
        logic [16:0] tc;
        logic [25:0] s;
        tc = AGE_ONE - t;
        s  = 26'(a) * 26'(tc) + 26'(b) * 26'(t);
        return s[23:16];
    endfunction

    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [16:0] t);
        logic [16:0] tc;
        logic [33:0] s;
        tc = AGE_ONE - t;
        s  = 34'(a) * 34'(tc) + 34'(b) * 34'(t);
        return s[31:16];
    endfunction

endpackage

// ===== rtl/ppu_ram.sv =====
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/ppu_front.sv =====
module ppu_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ppu_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic                                i_s_tuser,
    output logic                                o_q_valid,
    output ppu_pkg::t_cmd                       o_q_data,
    input  logic                                i_q_pop
);
    import ppu_pkg::*;

    t_fstate     r_state, n_state;
    t_cmd        r_item;
    logic [15:0] r_life;
    logic [15:0] r_rem;
    logic [24:0] r_quo;
    logic [4:0]  r_bit;

    t_cmd        r_q [QUEUE_DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    logic        s_xfer, push, full;
    logic [16:0] rem_sh, rem_sub;
    logic        ge;
    logic [24:0] quo_nx;
    t_cmd        in_item;

    assign o_s_tready = (r_state == F_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign full       = (r_cnt == 2'(QUEUE_DEPTH));
    assign push       = (r_state == F_PUSH) && !full;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_q[r_rp];

    // restoring divide of 2^24 by the life span, one quotient bit a cycle
    assign rem_sh  = {r_rem, (r_bit == 5'd24)};
    assign ge      = rem_sh >= {1'b0, r_life};
    assign rem_sub = rem_sh - {1'b0, r_life};
    assign quo_nx  = {r_quo[23:0], ge};

    always_comb begin
        in_item              = '0;
        in_item.cmd          = i_s_tuser;
        in_item.dt           = i_s_tdata[15:0];
        in_item.entry.pos    = i_s_tdata[63:16];
        in_item.entry.vel    = i_s_tdata[111:64];
        in_item.entry.axis   = i_s_tdata[159:112];
        in_item.entry.colour = {i_s_tdata[239:208], i_s_tdata[207:176]};
        in_item.entry.size   = i_s_tdata[271:240];
        in_item.entry.motion = {i_s_tdata[319:304], i_s_tdata[175:160], i_s_tdata[303:288]};
        in_item.entry.age    = '0;
        in_item.entry.rate   = 32'hFFFF_FFFF;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (s_xfer) begin
                    if (i_s_tuser == CMD_ADD && i_s_tdata[287:272] != 16'd0) begin
                        n_state = F_DIV;
                    end else begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                if (r_bit == 5'd0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_item <= in_item;
            r_life <= i_s_tdata[287:272];
            r_rem  <= '0;
            r_quo  <= '0;
            r_bit  <= 5'd24;
        end
        if (r_state == F_DIV) begin
            r_rem <= ge ? rem_sub[15:0] : rem_sh[15:0];
            r_quo <= quo_nx;
            r_bit <= r_bit - 5'd1;
            if (r_bit == 5'd0) begin
                r_item.entry.rate <= {7'd0, quo_nx};
            end
        end
        if (push) begin
            r_q[r_wp] <= r_item;
        end
    end

endmodule

// ===== rtl/ppu_back.sv =====
module ppu_back #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  ppu_pkg::t_cmd                       i_q_data,
    output logic                                o_q_pop,
    output logic                                o_ram_we,
    output logic [$clog2(MAX_PARTICLES)-1:0]    o_ram_addr,
    output ppu_pkg::t_entry                     o_ram_wdata,
    input  ppu_pkg::t_entry                     i_ram_rdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ppu_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic [1:0]                          o_m_tuser,
    output logic                                o_m_tlast
);
    import ppu_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);

    t_bstate            r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_i;
    logic [15:0]        r_dt;
    t_entry             r_e;
    logic signed [16:0] r_dp [3];
    logic signed [24:0] r_dv [3];
    logic [31:0]        r_kf;
    logic [31:0]        r_dage;
    logic [15:0]        r_dang;
    logic [47:0]        r_npos;
    logic [16:0]        r_age;
    logic [15:0]        r_ang;

    logic               can_add, dead, m_xfer;
    logic [47:0]        nvel;
    t_entry             upd;
    logic [32:0]        age_sum;
    logic [31:0]        colour;
    logic signed [32:0] dp_prod [3];
    logic signed [48:0] dv_prod [3];
    logic signed [32:0] dang_prod;

    assign can_add = r_count < CNT_W'(MAX_PARTICLES);
    assign dead    = r_age > AGE_ONE;
    assign m_xfer  = o_m_tvalid && i_m_tready;
    assign o_m_tvalid = (r_state == B_HOLD);
    assign age_sum = 33'(r_e.age) + 33'(r_dage);

    always_comb begin
        // full-width signed products, the step is taken from the upper bits
        for (int w = 0; w < 3; w++) begin
            dp_prod[w] = 33'($signed(i_ram_rdata.vel[16*w +: 16]))
                         * 33'($signed({1'b0, r_dt}));
            dv_prod[w] = 49'($signed(r_e.vel[16*w +: 16]))
                         * 49'($signed({1'b0, r_kf}));
        end
        dang_prod = 33'($signed(i_ram_rdata.motion[31:16])) * 33'($signed({1'b0, r_dt}));
        for (int w = 0; w < 3; w++) begin
            nvel[16*w +: 16] = sat16(26'($signed(r_e.vel[16*w +: 16])) - 26'(r_dv[w]));
        end
        upd             = r_e;
        upd.pos         = r_npos;
        upd.vel         = nvel;
        upd.age         = r_age;
        upd.motion      = {r_ang, r_e.motion[31:0]};
        for (int w = 0; w < 4; w++) begin
            colour[8*w +: 8] = lerp8(i_ram_rdata.colour[8*w +: 8],
                                     i_ram_rdata.colour[32+8*w +: 8], i_ram_rdata.age);
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_i[AW-1:0];
        o_ram_wdata = upd;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.cmd == CMD_ADD) begin
                        o_ram_we    = can_add;
                        o_ram_addr  = r_count[AW-1:0];
                        o_ram_wdata = i_q_data.entry;
                        n_state     = B_HOLD;
                    end else begin
                        n_state = B_RD;
                    end
                end
            end
            B_RD: begin
                if (r_i < r_count) begin
                    n_state = B_M1;
                end else if (r_count == '0) begin
                    n_state = B_HOLD;
                end else begin
                    n_state = B_ERD;
                end
            end
            B_M1: n_state = B_M2;
            B_M2: n_state = B_M3;
            B_M3: begin
                o_ram_we = 1'b1;
                n_state  = dead ? B_MVRD : B_RD;
            end
            B_MVRD: begin
                o_ram_addr = r_count[AW-1:0];
                n_state    = B_MVWR;
            end
            B_MVWR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = i_ram_rdata;
                n_state     = B_RD;
            end
            B_ERD: n_state = B_EL;
            B_EL:  n_state = B_HOLD;
            B_HOLD: begin
                if (m_xfer) begin
                    n_state = o_m_tlast ? B_IDLE : B_ERD;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_i <= '0;
                        if (i_q_data.cmd == CMD_ADD && can_add) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                B_RD: begin
                    if (!(r_i < r_count)) begin
                        r_i <= '0;
                    end
                end
                B_M3: begin
                    if (dead) begin
                        r_count <= r_count - CNT_W'(1);
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                B_HOLD: begin
                    if (m_xfer && !o_m_tlast) begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_dt      <= i_q_data.dt;
                o_m_tuser <= KIND_ACK;
                o_m_tlast <= 1'b1;
                o_m_tdata <= {160'd0, (can_add ? r_count + CNT_W'(1) : r_count), can_add};
            end
            B_RD: begin
                o_m_tuser <= KIND_EMPTY;
                o_m_tlast <= 1'b1;
                o_m_tdata <= '0;
            end
            B_M1: begin
                r_e <= i_ram_rdata;
                for (int w = 0; w < 3; w++) begin
                    r_dp[w] <= dp_prod[w][32:16];
                end
                r_kf   <= 32'(i_ram_rdata.motion[15:0]) * 32'(r_dt);
                r_dage <= 32'((48'(r_dt) * 48'(i_ram_rdata.rate)) >> 16);
                r_dang <= dang_prod[31:16];
            end
            B_M2: begin
                for (int w = 0; w < 3; w++) begin
                    r_dv[w] <= dv_prod[w][48:24];
                    r_npos[16*w +: 16] <= sat16(26'($signed(r_e.pos[16*w +: 16]))
                                                + 26'(r_dp[w]));
                end
                r_age <= (age_sum > 33'(AGE_MAX)) ? AGE_MAX : age_sum[16:0];
                r_ang <= r_e.motion[47:32] + r_dang;
            end
            B_EL: begin
                o_m_tuser <= KIND_RECORD;
                o_m_tlast <= (r_i == r_count - CNT_W'(1));
                o_m_tdata <= {i_ram_rdata.motion[47:32], i_ram_rdata.axis,
                              lerp16(i_ram_rdata.size[15:0], i_ram_rdata.size[31:16],
                                     i_ram_rdata.age),
                              colour, i_ram_rdata.pos, r_count, 1'b0};
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/particle_pool_update_engine_top.sv =====
// particle pool update engine
// input channel (s): one transfer is one command. tuser = 0 adds a particle,
// tuser = 1 ticks the whole pool by time_step.
// output channel (m): an add answers with one acknowledgement (tuser 0);
// a tick answers with one record per surviving particle (tuser 1), or one
// empty record (tuser 2) when none survive. tlast marks the final record.
// a front stage takes commands and derives the age rate with a bit-serial
// divider for an add with nonzero life span, then writes the queue (other
// commands go straight to the queue write; s_tready is low meanwhile); a
// two-entry queue feeds the back stage, which walks the pool in a single-port
// ram. an add is written to the ram as it leaves the queue (if the pool has
// room); its acknowledgement is then held in the output register. a tick
// first updates each live particle in place, moving the last entry into the
// slot of each removed one, then reads out and emits each record in turn.
// when the receiver stalls, the record is held in the output register and
// the back stage waits; the front accepts until the queue fills and it holds one more.
// reset is synchronous, active low, and empties the pool and the queue;
// ram contents are not cleared.
module particle_pool_update_engine_top #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // time_step, position_xyz, velocity_xyz, axis_xyz, spin_rate, start_colour,
    // final_colour, size_pair, life_span, damping_factor, initial_angle
    input  logic [ppu_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // command
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // accepted, live_total, out_position, out_colour, out_size, out_axis, out_angle
    output logic [ppu_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // record_kind
    output logic [1:0]                      o_m_tuser,
    output logic                            o_m_tlast
);
    import ppu_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);

    logic            q_valid, q_pop;
    t_cmd            q_data;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    t_entry          ram_wdata, ram_rdata;

    ppu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_data   (q_data),
        .i_q_pop    (q_pop)
    );

    ppu_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_PARTICLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    ppu_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== rtl/ppu_checker.sv =====
module ppu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [ppu_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [ppu_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [1:0]                      o_m_tuser,
    input logic                            o_m_tlast
);
    import ppu_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata)
            && $stable(i_s_tuser))
        else $error("input changed while waiting");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_EMPTY |-> o_m_tlast && o_m_tdata == '0)
        else $error("empty tick record not clean");

    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_ACK |-> o_m_tlast && o_m_tdata[167:8] == '0)
        else $error("add acknowledgement not clean");

    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_RECORD |-> !o_m_tdata[0] && o_m_tdata[7:1] != '0)
        else $error("particle record with empty pool");

endmodule

bind particle_pool_update_engine_top ppu_checker u_chk (.*);
